FILE: rtl/core/msie_pkg.sv
// shared types, codes and helpers for the mips subset executor
package msie_pkg;

    localparam int XLEN     = 32;
    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = 5;

    // bus request kinds
    localparam logic [1:0] KIND_FETCH = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_HALT  = 2'd3;

    // input item codes
    localparam logic OP_INSTR = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    // primary opcodes
    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_J       = 6'h02;
    localparam logic [5:0] OPC_BEQ     = 6'h04;
    localparam logic [5:0] OPC_BNE     = 6'h05;
    localparam logic [5:0] OPC_BLEZ    = 6'h06;
    localparam logic [5:0] OPC_BGTZ    = 6'h07;
    localparam logic [5:0] OPC_ADDI    = 6'h08;
    localparam logic [5:0] OPC_SLTI    = 6'h0a;
    localparam logic [5:0] OPC_ANDI    = 6'h0c;
    localparam logic [5:0] OPC_ORI     = 6'h0d;
    localparam logic [5:0] OPC_LUI     = 6'h0f;
    localparam logic [5:0] OPC_LW      = 6'h23;
    localparam logic [5:0] OPC_SW      = 6'h2b;

    // function codes of the special opcode
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_SLLV = 6'h04;
    localparam logic [5:0] FN_SRLV = 6'h06;
    localparam logic [5:0] FN_SRAV = 6'h07;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_SLT  = 6'h2a;

    typedef struct packed {
        logic               op;
        logic [31:0]        instruction_word;
        logic signed [31:0] load_data;
    } msie_in_t;

    typedef struct packed {
        logic [1:0]         access_kind;
        logic [31:0]        bus_address;
        logic signed [31:0] store_value;
        logic               last;
    } msie_out_t;

    // state updates worked out for one item
    typedef struct packed {
        logic             rf_we;
        logic [RF_AW-1:0] rf_waddr;
        logic [XLEN-1:0]  rf_wdata;
        logic [XLEN-1:0]  lo_next;
        logic [XLEN-1:0]  pc_next;
        logic [RF_AW-1:0] target_next;
        logic             await_next;
        logic             stop_next;
        logic [1:0]       n_res;
    } msie_fx_t;

    function automatic msie_out_t make_res(logic [1:0] kind, logic [31:0] addr,
                                           logic [31:0] val, logic last);
        msie_out_t r;
        r.access_kind = kind;
        r.bus_address = addr;
        r.store_value = $signed(val);
        r.last        = last;
        return r;
    endfunction

endpackage

FILE: rtl/core/msie_ram.sv
// generic ram, one write port and two registered read ports
module msie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: rtl/core/msie_regfile.sv
// general register file: ram with valid bits and write forwarding
module msie_regfile (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         re,
    input  logic [msie_pkg::RF_AW-1:0]   raddr_a,
    input  logic [msie_pkg::RF_AW-1:0]   raddr_b,
    input  logic                         we,
    input  logic [msie_pkg::RF_AW-1:0]   waddr,
    input  logic [msie_pkg::XLEN-1:0]    wdata,
    output logic [msie_pkg::XLEN-1:0]    rdata_a,
    output logic [msie_pkg::XLEN-1:0]    rdata_b
);

    logic [msie_pkg::RF_DEPTH-1:0] valid_reg;
    logic [msie_pkg::RF_AW-1:0]    ra_reg;
    logic [msie_pkg::RF_AW-1:0]    rb_reg;
    logic                          va_reg;
    logic                          vb_reg;
    logic                          fwd_we_reg;
    logic [msie_pkg::RF_AW-1:0]    fwd_addr_reg;
    logic [msie_pkg::XLEN-1:0]     fwd_data_reg;
    logic [msie_pkg::XLEN-1:0]     ram_a;
    logic [msie_pkg::XLEN-1:0]     ram_b;
    logic                          we_eff;

    // register 0 is never stored, so it stays invalid and reads as zero
    assign we_eff = we && (waddr != '0);

    msie_ram #(
        .WIDTH (msie_pkg::XLEN),
        .DEPTH (msie_pkg::RF_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (we_eff),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            va_reg     <= 1'b0;
            vb_reg     <= 1'b0;
            fwd_we_reg <= 1'b0;
        end else begin
            if (we_eff) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re) begin
                va_reg <= valid_reg[raddr_a];
                vb_reg <= valid_reg[raddr_b];
            end
            // the latest write is always current, so it may be forwarded at any time
            if (we_eff) begin
                fwd_we_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            ra_reg <= raddr_a;
            rb_reg <= raddr_b;
        end
        if (we_eff) begin
            fwd_addr_reg <= waddr;
            fwd_data_reg <= wdata;
        end
    end

    always_comb begin
        if (fwd_we_reg && (fwd_addr_reg == ra_reg)) begin
            rdata_a = fwd_data_reg;
        end else begin
            rdata_a = va_reg ? ram_a : '0;
        end
        if (fwd_we_reg && (fwd_addr_reg == rb_reg)) begin
            rdata_b = fwd_data_reg;
        end else begin
            rdata_b = vb_reg ? ram_b : '0;
        end
    end

    a_r0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[0])
        else $error("register 0 marked as written");

endmodule

FILE: rtl/core/msie_exec.sv
// decode and execute of one item, with the results it causes
module msie_exec (
    input  msie_pkg::msie_in_t               item,
    input  logic [msie_pkg::XLEN-1:0]        a,
    input  logic [msie_pkg::XLEN-1:0]        b,
    input  logic [msie_pkg::XLEN-1:0]        lo,
    input  logic [msie_pkg::XLEN-1:0]        pc,
    input  logic [msie_pkg::RF_AW-1:0]       target,
    input  logic                             awaiting,
    input  logic                             stopped,
    output msie_pkg::msie_fx_t               fx,
    output msie_pkg::msie_out_t              res0,
    output msie_pkg::msie_out_t              res1
);

    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [15:0] imm;
    logic [31:0] ext;
    logic [31:0] pc4;
    logic [31:0] br_target;
    logic [31:0] mem_addr;
    logic [31:0] product;
    logic [31:0] next_pc;
    logic        bad;
    logic        take;
    logic        wr;
    logic [4:0]  wr_addr;
    logic [31:0] wr_val;

    assign opc       = item.instruction_word[31:26];
    assign rs        = item.instruction_word[25:21];
    assign rt        = item.instruction_word[20:16];
    assign rd        = item.instruction_word[15:11];
    assign sh        = item.instruction_word[10:6];
    assign fn        = item.instruction_word[5:0];
    assign imm       = item.instruction_word[15:0];
    assign ext       = {{16{imm[15]}}, imm};
    assign pc4       = pc + 32'd4;
    assign br_target = pc4 + {ext[29:0], 2'b00};
    assign mem_addr  = a + ext;
    assign product   = a * b;

    // instruction decode and register write value
    always_comb begin
        bad     = 1'b0;
        take    = 1'b0;
        wr      = 1'b0;
        wr_addr = rt;
        wr_val  = '0;
        next_pc = pc4;
        case (opc)
            msie_pkg::OPC_SPECIAL: begin
                wr      = 1'b1;
                wr_addr = rd;
                case (fn)
                    msie_pkg::FN_ADD:  wr_val = a + b;
                    msie_pkg::FN_SUB:  wr_val = a - b;
                    msie_pkg::FN_SLL:  wr_val = b << sh;
                    msie_pkg::FN_SLLV: wr_val = b << a[4:0];
                    msie_pkg::FN_SRL:  wr_val = b >> sh;
                    msie_pkg::FN_SRLV: wr_val = b >> a[4:0];
                    msie_pkg::FN_SRA:  wr_val = $unsigned($signed(b) >>> sh);
                    msie_pkg::FN_SRAV: wr_val = $unsigned($signed(b) >>> a[4:0]);
                    msie_pkg::FN_MFLO: wr_val = lo;
                    msie_pkg::FN_AND:  wr_val = a & b;
                    msie_pkg::FN_OR:   wr_val = a | b;
                    msie_pkg::FN_XOR:  wr_val = a ^ b;
                    msie_pkg::FN_SLT:  wr_val = {31'd0, $signed(a) < $signed(b)};
                    msie_pkg::FN_MULT: wr = 1'b0;
                    default: begin
                        wr  = 1'b0;
                        bad = 1'b1;
                    end
                endcase
            end
            msie_pkg::OPC_ADDI: begin
                wr     = 1'b1;
                wr_val = a + ext;
            end
            msie_pkg::OPC_ANDI: begin
                wr     = 1'b1;
                wr_val = a & ext;
            end
            msie_pkg::OPC_ORI: begin
                wr     = 1'b1;
                wr_val = a | ext;
            end
            msie_pkg::OPC_SLTI: begin
                wr     = 1'b1;
                wr_val = {31'd0, $signed(a) < $signed(ext)};
            end
            msie_pkg::OPC_LUI: begin
                wr     = 1'b1;
                wr_val = {imm, 16'd0};
            end
            msie_pkg::OPC_LW: ;
            msie_pkg::OPC_SW: ;
            msie_pkg::OPC_BEQ:  take = (a == b);
            msie_pkg::OPC_BNE:  take = (a != b);
            msie_pkg::OPC_BLEZ: take = (a == '0) || a[31];
            msie_pkg::OPC_BGTZ: take = (a != '0) && !a[31];
            msie_pkg::OPC_J: next_pc = {pc4[31:28], item.instruction_word[25:0], 2'b00};
            default: bad = 1'b1;
        endcase
        if (take) begin
            next_pc = br_target;
        end
    end

    // effects on state and the results emitted
    always_comb begin
        fx.rf_we       = 1'b0;
        fx.rf_waddr    = wr_addr;
        fx.rf_wdata    = wr_val;
        fx.lo_next     = lo;
        fx.pc_next     = pc;
        fx.target_next = target;
        fx.await_next  = awaiting;
        fx.stop_next   = stopped;
        fx.n_res       = 2'd0;
        res0 = msie_pkg::make_res(msie_pkg::KIND_HALT, pc, '0, 1'b1);
        res1 = msie_pkg::make_res(msie_pkg::KIND_FETCH, next_pc, '0, 1'b1);
        if (stopped) begin
            fx.n_res = 2'd1;
        end else if (item.op == msie_pkg::OP_LOAD) begin
            if (awaiting) begin
                fx.rf_we      = 1'b1;
                fx.rf_waddr   = target;
                fx.rf_wdata   = $unsigned(item.load_data);
                fx.await_next = 1'b0;
                fx.n_res      = 2'd1;
                res0 = msie_pkg::make_res(msie_pkg::KIND_FETCH, pc, '0, 1'b1);
            end
        end else if (!awaiting) begin
            fx.n_res = 2'd1;
            if (bad) begin
                fx.stop_next = 1'b1;
            end else begin
                fx.rf_we   = wr;
                fx.pc_next = next_pc;
                if ((opc == msie_pkg::OPC_SPECIAL) && (fn == msie_pkg::FN_MULT)) begin
                    fx.lo_next = product;
                end
                if (opc == msie_pkg::OPC_LW) begin
                    fx.target_next = rt;
                    fx.await_next  = 1'b1;
                    res0 = msie_pkg::make_res(msie_pkg::KIND_READ, mem_addr, '0, 1'b1);
                end else if (opc == msie_pkg::OPC_SW) begin
                    fx.n_res = 2'd2;
                    res0 = msie_pkg::make_res(msie_pkg::KIND_WRITE, mem_addr, b, 1'b0);
                end else begin
                    res0 = msie_pkg::make_res(msie_pkg::KIND_FETCH, next_pc, '0, 1'b1);
                end
            end
        end
    end

endmodule

FILE: rtl/core/msie_resq.sv
// two-entry result queue in front of the result channel
module msie_resq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [1:0]           n_push,
    input  msie_pkg::msie_out_t  res0,
    input  msie_pkg::msie_out_t  res1,
    output logic                 space,
    output logic                 m_valid,
    input  logic                 m_ready,
    output msie_pkg::msie_out_t  m_item
);

    msie_pkg::msie_out_t slot0_reg;
    msie_pkg::msie_out_t slot1_reg;
    logic [1:0]          cnt_reg;
    logic                pop;
    logic [1:0]          rem;

    assign pop     = (cnt_reg != 2'd0) && m_ready;
    assign rem     = cnt_reg - {1'b0, pop};
    // a new item may enter only once the queue drains this cycle
    assign space   = (rem == 2'd0);
    assign m_valid = (cnt_reg != 2'd0);
    assign m_item  = slot0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (push) begin
            cnt_reg <= n_push;
        end else begin
            cnt_reg <= rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result queue overfilled");

    a_push_space: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> space)
        else $error("result pushed without room");

endmodule

FILE: rtl/core/mips_subset_instruction_executor.sv
// top level of the mips subset executor
// Takes one item (a fetched instruction word or returned load data) per cycle while the result
// port takes each result, and answers with the next bus request. The item is loaded into
// the input register while its source registers are read from the register file, and is
// then executed into the result queue once the queue has room; the queue drives the result
// port. A store produces two results (the write, then the fetch), and the item after it
// waits to execute until both have left the queue. The register file comes out of reset
// all zero through per-register valid bits, so no clearing pass is needed. A write on the
// cfg port loads the program counter and is taken only while no item waits to execute.
module mips_subset_instruction_executor (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_start_address,
    input  logic                s_valid,
    output logic                s_ready,
    input  msie_pkg::msie_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output msie_pkg::msie_out_t m_item
);

    logic                          ex_valid_reg;
    msie_pkg::msie_in_t            ex_item_reg;
    logic [msie_pkg::XLEN-1:0]     pc_reg;
    logic [msie_pkg::XLEN-1:0]     lo_reg;
    logic [msie_pkg::RF_AW-1:0]    target_reg;
    logic                          awaiting_reg;
    logic                          stopped_reg;
    logic                          s_fire;
    logic                          ex_fire;
    logic                          space;
    logic [msie_pkg::XLEN-1:0]     rs_data;
    logic [msie_pkg::XLEN-1:0]     rt_data;
    msie_pkg::msie_fx_t            fx;
    msie_pkg::msie_out_t           res0;
    msie_pkg::msie_out_t           res1;

    assign cfg_ready = !ex_valid_reg;
    assign ex_fire   = ex_valid_reg && space;
    assign s_ready   = !ex_valid_reg || ex_fire;
    assign s_fire    = s_valid && s_ready;

    msie_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .re      (s_fire),
        .raddr_a (s_item.instruction_word[25:21]),
        .raddr_b (s_item.instruction_word[20:16]),
        .we      (ex_fire && fx.rf_we),
        .waddr   (fx.rf_waddr),
        .wdata   (fx.rf_wdata),
        .rdata_a (rs_data),
        .rdata_b (rt_data)
    );

    msie_exec u_exec (
        .item     (ex_item_reg),
        .a        (rs_data),
        .b        (rt_data),
        .lo       (lo_reg),
        .pc       (pc_reg),
        .target   (target_reg),
        .awaiting (awaiting_reg),
        .stopped  (stopped_reg),
        .fx       (fx),
        .res0     (res0),
        .res1     (res1)
    );

    msie_resq u_resq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (ex_fire),
        .n_push  (fx.n_res),
        .res0    (res0),
        .res1    (res1),
        .space   (space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
            pc_reg       <= '0;
            lo_reg       <= '0;
            target_reg   <= '0;
            awaiting_reg <= 1'b0;
            stopped_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                ex_valid_reg <= 1'b1;
            end else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire) begin
                lo_reg       <= fx.lo_next;
                target_reg   <= fx.target_next;
                awaiting_reg <= fx.await_next;
                stopped_reg  <= fx.stop_next;
            end
            if (cfg_valid && cfg_ready) begin
                pc_reg <= cfg_start_address;
            end else if (ex_fire) begin
                pc_reg <= fx.pc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ex_item_reg <= s_item;
        end
    end

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("halt state left without reset");

    a_halt_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stopped_reg && awaiting_reg))
        else $error("halted with a load outstanding");

    a_store_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_fire && (fx.n_res == 2'd2)) |-> (res0.access_kind == msie_pkg::KIND_WRITE))
        else $error("two results from an item that is not a store");

endmodule
